FILE: rtl/segment_translate_tlb_refill_core_macros.svh
// Assertion macros for the segment translate TLB refill core.
// Included by the top level; needs no package.
`ifndef SEGMENT_TRANSLATE_TLB_REFILL_CORE_MACROS_SVH
`define SEGMENT_TRANSLATE_TLB_REFILL_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define STT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen outside reset.
`define STT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define STT_ASSERT(lbl, clk, rst_n, prop, msg)

`define STT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/sttlb_pkg.sv
// Shared types and codes for the segment translate TLB refill core.
// No dependencies; imported by every module of the block.
`default_nettype none

package sttlb_pkg;

    localparam int PAGE_W     = 20;
    localparam int ADDR_W     = 32;
    localparam int OFFSET_W   = 12;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 3;
    localparam int INDEX_W    = 6;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READONLY = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INVAL    = 3'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_REQ  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_READONLY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // Register indexes (word address bits of paddr).
    localparam logic [2:0] REG_CODE_VIRT  = 3'd0;
    localparam logic [2:0] REG_CODE_PHYS  = 3'd1;
    localparam logic [2:0] REG_CODE_COUNT = 3'd2;
    localparam logic [2:0] REG_DATA_VIRT  = 3'd3;
    localparam logic [2:0] REG_DATA_PHYS  = 3'd4;
    localparam logic [2:0] REG_DATA_COUNT = 3'd5;
    localparam logic [2:0] REG_STACK_PHYS = 3'd6;

    typedef logic [PAGE_W-1:0] page_t;

    typedef struct packed {
        page_t code_virt;
        page_t code_phys;
        page_t code_count;
        page_t data_virt;
        page_t data_phys;
        page_t data_count;
        page_t stack_phys;
    } seg_cfg_t;

    typedef struct packed {
        logic  hit;
        page_t ppn;
    } seg_match_t;

endpackage

`default_nettype wire

FILE: rtl/segment_translate_tlb_refill_core.sv
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_stall   req_type, fault_addr
// output   out        out_valid / out_stall status, entry_written, entry_index,
//                                           entry_virt_page, entry_phys_page
// config   in         APB (psel, penable)   pwdata -> 20-bit segment registers
//
// One transfer is taken each cycle while the input is not stalled; its result passes
// from the input register into the result register, which presents it.
// The only dependence between requests is the TLB fill count, which is updated
// as a result is registered, so the next request sees it at once.
// Reset empties the TLB (fill count zero) and zeroes the segment registers.
// A stall on the output holds the result register, then the input register.
//
// Top level of the segment translate TLB refill core.
// Depends on sttlb_pkg, sttlb_regs, sttlb_seg and the assertion macro header.
`default_nettype none

`include "segment_translate_tlb_refill_core_macros.svh"

module segment_translate_tlb_refill_core
    import sttlb_pkg::*;
#(
    parameter int TLB_ENTRIES    = 64,
    parameter int STACK_PAGES    = 18,
    parameter int STACK_TOP_PAGE = 524288
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [REQ_W-1:0]      req_type,
    input  wire logic [ADDR_W-1:0]     fault_addr,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [STATUS_W-1:0]   status,
    output logic                       entry_written,
    output logic      [INDEX_W-1:0]    entry_index,
    output logic      [PAGE_W-1:0]     entry_virt_page,
    output logic      [PAGE_W-1:0]     entry_phys_page,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam int CNT_W = $clog2(TLB_ENTRIES + 1);

    seg_cfg_t          cfg;
    seg_match_t        match;

    logic              in_valid_reg;
    logic [REQ_W-1:0]  req_reg;
    page_t             vpn_reg;

    // Entries fill lowest first and are only cleared all together, so the valid
    // entries are always a prefix and a count stands for the valid bits.
    logic [CNT_W-1:0]  fill_cnt_reg;
    logic [CNT_W-1:0]  fill_cnt_next;

    logic              out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic              written_reg;
    logic              written_next;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;
    page_t             vpage_reg;
    page_t             vpage_next;
    page_t             ppage_reg;
    page_t             ppage_next;

    logic              out_load;
    logic              in_take;
    logic              tlb_full;
    logic [IDX_W+INDEX_W-1:0] index_wide;

    sttlb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sttlb_seg #(
        .STACK_PAGES    (STACK_PAGES),
        .STACK_TOP_PAGE (STACK_TOP_PAGE)
    ) u_seg
    (
        .vpn   (vpn_reg),
        .cfg   (cfg),
        .match (match)
    );

    assign out_load = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg <= req_type;
            vpn_reg <= fault_addr[ADDR_W-1:OFFSET_W];
        end
    end

    assign tlb_full   = (fill_cnt_reg == CNT_W'(TLB_ENTRIES));
    assign index_wide = {{INDEX_W{1'b0}}, fill_cnt_reg[IDX_W-1:0]};

    always_comb
    begin
        status_next   = ST_OK;
        written_next  = 1'b0;
        index_next    = '0;
        vpage_next    = '0;
        ppage_next    = '0;
        fill_cnt_next = fill_cnt_reg;
        case (req_reg)
            REQ_READ, REQ_WRITE:
            begin
                if (!match.hit)
                begin
                    status_next = ST_OUTSIDE;
                end
                else if (tlb_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    written_next  = 1'b1;
                    index_next    = index_wide[INDEX_W-1:0];
                    vpage_next    = vpn_reg;
                    ppage_next    = match.ppn;
                    fill_cnt_next = fill_cnt_reg + 1'b1;
                end
            end
            REQ_READONLY:
            begin
                status_next = ST_READONLY;
            end
            REQ_INVAL:
            begin
                fill_cnt_next = '0;
            end
            default:
            begin
                status_next = ST_BAD_REQ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fill_cnt_reg  <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                fill_cnt_reg <= fill_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            status_reg  <= status_next;
            written_reg <= written_next;
            index_reg   <= index_next;
            vpage_reg   <= vpage_next;
            ppage_reg   <= ppage_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign entry_written   = written_reg;
    assign entry_index     = index_reg;
    assign entry_virt_page = vpage_reg;
    assign entry_phys_page = ppage_reg;

    `STT_ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_cnt_reg > CNT_W'(TLB_ENTRIES),
        "TLB fill count beyond entry count")
    `STT_ASSERT(a_stall_chain, clk, rst_n, in_stall |-> (out_valid_reg && out_stall),
        "input stalled while result register free")
    `STT_ASSERT(a_inval_empties, clk, rst_n,
        (out_load && in_valid_reg && req_reg == REQ_INVAL) |=> (fill_cnt_reg == '0),
        "invalidate did not empty the TLB")
    `STT_ASSERT(a_fill_counts, clk, rst_n,
        (out_load && in_valid_reg && written_next) |=>
            (fill_cnt_reg == $past(fill_cnt_reg) + 1'b1),
        "entry fill did not advance the count")

endmodule

`default_nettype wire

FILE: rtl/sttlb_regs.sv
// APB register file holding the segment bases and page counts.
// Depends on sttlb_pkg.
`default_nettype none

module sttlb_regs
    import sttlb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output seg_cfg_t                   cfg
);

    seg_cfg_t    cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_sel;
    page_t       wr_page;
    page_t       rd_page;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];
    assign wr_page = pwdata[PAGE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_CODE_VIRT:  cfg_reg.code_virt  <= wr_page;
                REG_CODE_PHYS:  cfg_reg.code_phys  <= wr_page;
                REG_CODE_COUNT: cfg_reg.code_count <= wr_page;
                REG_DATA_VIRT:  cfg_reg.data_virt  <= wr_page;
                REG_DATA_PHYS:  cfg_reg.data_phys  <= wr_page;
                REG_DATA_COUNT: cfg_reg.data_count <= wr_page;
                REG_STACK_PHYS: cfg_reg.stack_phys <= wr_page;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CODE_VIRT:  rd_page = cfg_reg.code_virt;
            REG_CODE_PHYS:  rd_page = cfg_reg.code_phys;
            REG_CODE_COUNT: rd_page = cfg_reg.code_count;
            REG_DATA_VIRT:  rd_page = cfg_reg.data_virt;
            REG_DATA_PHYS:  rd_page = cfg_reg.data_phys;
            REG_DATA_COUNT: rd_page = cfg_reg.data_count;
            REG_STACK_PHYS: rd_page = cfg_reg.stack_phys;
            default:        rd_page = '0;
        endcase
    end

    assign prdata = {{(CFG_DATA_W-PAGE_W){1'b0}}, rd_page};
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/sttlb_seg.sv
// Segment lookup: matches a virtual page against code, data and stack
// and forms the physical page. Depends on sttlb_pkg.
`default_nettype none

module sttlb_seg
    import sttlb_pkg::*;
#(
    parameter int STACK_PAGES    = 18,
    parameter int STACK_TOP_PAGE = 524288
)
(
    input  wire page_t    vpn,
    input  wire seg_cfg_t cfg,
    output seg_match_t    match
);

    // The stack base saturates at page zero when the stack is taller than its top.
    localparam int    STACK_BASE_INT = (STACK_TOP_PAGE > STACK_PAGES) ?
                                       (STACK_TOP_PAGE - STACK_PAGES) : 0;
    localparam page_t STACK_BASE     = PAGE_W'(STACK_BASE_INT);
    localparam page_t STACK_TOP      = PAGE_W'(STACK_TOP_PAGE);

    logic [PAGE_W:0] vpn_x;
    logic [PAGE_W:0] code_end;
    logic [PAGE_W:0] data_end;
    logic            code_hit;
    logic            data_hit;
    logic            stack_hit;
    page_t           code_ppn;
    page_t           data_ppn;
    page_t           stack_ppn;

    // Bounds are formed one bit wider so that base plus count never wraps.
    assign vpn_x    = {1'b0, vpn};
    assign code_end = {1'b0, cfg.code_virt} + {1'b0, cfg.code_count};
    assign data_end = {1'b0, cfg.data_virt} + {1'b0, cfg.data_count};

    assign code_hit  = (vpn >= cfg.code_virt) && (vpn_x < code_end);
    assign data_hit  = (vpn >= cfg.data_virt) && (vpn_x < data_end);
    assign stack_hit = (vpn >= STACK_BASE) && (vpn < STACK_TOP);

    assign code_ppn  = vpn - cfg.code_virt + cfg.code_phys;
    assign data_ppn  = vpn - cfg.data_virt + cfg.data_phys;
    assign stack_ppn = vpn - STACK_BASE + cfg.stack_phys;

    always_comb
    begin
        match.hit = code_hit || data_hit || stack_hit;
        if (code_hit)
        begin
            match.ppn = code_ppn;
        end
        else if (data_hit)
        begin
            match.ppn = data_ppn;
        end
        else
        begin
            match.ppn = stack_ppn;
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the segment translate TLB refill core.
// Depends on sttlb_pkg and the core RTL; drives transfers and APB writes,
// and checks every result against an in-bench model of the segment lookup and TLB fill.
`default_nettype none

module tb_top
    import sttlb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TLB_N       = 64;
    localparam int          STACK_N     = 18;
    localparam int          STACK_TOP   = 524288;
    localparam int unsigned STACK_BASE  = (STACK_TOP > STACK_N) ? STACK_TOP - STACK_N : 0;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 160;

    // Request codes that the block must reject.
    localparam logic [REQ_W-1:0] REQ_RSVD4 = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                written;
        logic [INDEX_W-1:0]  index;
        page_t               vpage;
        page_t               ppage;
    } refill_t;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        refill_t           want;
    } fault_row_t;

    localparam int DIR_N = 19;

    // Reset configuration: only the stack segment, pages 0x7FFEE..0x7FFFF onto frames 0..17.
    fault_row_t fault_rows [DIR_N] = '{
        '{REQ_READ,     32'h0000_0000, 1'b1, '{ST_OUTSIDE,  1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_WRITE,    32'hFFFF_FFFF, 1'b1, '{ST_OUTSIDE,  1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_READ,     32'h7FFE_E000, 1'b1, '{ST_OK, 1'b1, 6'd0, 20'h7FFEE, 20'h0}},
        '{REQ_WRITE,    32'h7FFF_FFFF, 1'b1, '{ST_OK, 1'b1, 6'd1, 20'h7FFFF, 20'h11}},
        '{REQ_READ,     32'h7FFE_DFFF, 1'b1, '{ST_OUTSIDE,  1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_WRITE,    32'h8000_0000, 1'b1, '{ST_OUTSIDE,  1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_READONLY, 32'h7FFE_E000, 1'b1, '{ST_READONLY, 1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_RSVD4,    32'h7FFF_0000, 1'b1, '{ST_BAD_REQ,  1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_RSVD5,    32'h7FFF_1000, 1'b1, '{ST_BAD_REQ,  1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_RSVD6,    32'h7FFF_2000, 1'b1, '{ST_BAD_REQ,  1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_RSVD7,    32'h7FFF_3000, 1'b1, '{ST_BAD_REQ,  1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_READ,     32'h7FFF_0ABC, 1'b0, '0},
        '{REQ_WRITE,    32'h7FFF_5123, 1'b0, '0},
        '{REQ_INVAL,    32'h0000_0000, 1'b1, '{ST_OK, 1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_WRITE,    32'h7FFF_A5A5, 1'b0, '0},
        '{REQ_INVAL,    32'hFFFF_FFFF, 1'b1, '{ST_OK, 1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_READ,     32'h7FFE_E800, 1'b1, '{ST_OK, 1'b1, 6'd0, 20'h7FFEE, 20'h0}},
        '{REQ_READONLY, 32'hFFFF_FFFF, 1'b1, '{ST_READONLY, 1'b0, 6'd0, 20'h0, 20'h0}},
        '{REQ_READ,     32'h7FFF_F000, 1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [REQ_W-1:0]      req_type = '0;
    logic [ADDR_W-1:0]     fault_addr = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic                  entry_written;
    logic [INDEX_W-1:0]    entry_index;
    logic [PAGE_W-1:0]     entry_virt_page;
    logic [PAGE_W-1:0]     entry_phys_page;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    page_t            seg_regs [7];
    logic [TLB_N-1:0] tlb_valid;
    refill_t          pending_refills [$];
    refill_t          oldest_refill;
    int               mismatches = 0;
    int               cycle_count = 0;
    int               src_idle_pct = 0;
    int               sink_stall_pct = 0;

    segment_translate_tlb_refill_core #(
        .TLB_ENTRIES    (TLB_N),
        .STACK_PAGES    (STACK_N),
        .STACK_TOP_PAGE (STACK_TOP)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .fault_addr      (fault_addr),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .entry_written   (entry_written),
        .entry_index     (entry_index),
        .entry_virt_page (entry_virt_page),
        .entry_phys_page (entry_phys_page),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Segment lookup and TLB fill for one accepted request; updates the valid bits.
    function automatic refill_t predict_refill(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr);
        refill_t     r;
        page_t       vpn;
        page_t       ppn;
        int unsigned v;
        bit          hit;
        bit          found;
        r = '0;
        vpn = addr[ADDR_W-1:OFFSET_W];
        v = vpn;
        hit = 1'b1;
        found = 1'b0;
        ppn = '0;
        case (kind)
            REQ_INVAL:
            begin
                tlb_valid = '0;
                r.status = ST_OK;
            end
            REQ_READONLY:
                r.status = ST_READONLY;
            REQ_READ, REQ_WRITE:
            begin
                // Bounds are summed at 32 bits so a segment never wraps past page 0xFFFFF.
                if (v >= 32'(seg_regs[REG_CODE_VIRT]) &&
                    v < 32'(seg_regs[REG_CODE_VIRT]) + 32'(seg_regs[REG_CODE_COUNT]))
                    ppn = page_t'(v - 32'(seg_regs[REG_CODE_VIRT]) + 32'(seg_regs[REG_CODE_PHYS]));
                else if (v >= 32'(seg_regs[REG_DATA_VIRT]) &&
                         v < 32'(seg_regs[REG_DATA_VIRT]) + 32'(seg_regs[REG_DATA_COUNT]))
                    ppn = page_t'(v - 32'(seg_regs[REG_DATA_VIRT]) + 32'(seg_regs[REG_DATA_PHYS]));
                else if (v >= STACK_BASE && v < STACK_TOP)
                    ppn = page_t'(v - STACK_BASE + 32'(seg_regs[REG_STACK_PHYS]));
                else
                    hit = 1'b0;
                if (!hit)
                    r.status = ST_OUTSIDE;
                else
                begin
                    r.status = ST_FULL;
                    for (int i = 0; i < TLB_N; i++)
                    begin
                        if (!found && !tlb_valid[i])
                        begin
                            found = 1'b1;
                            tlb_valid[i] = 1'b1;
                            r.status = ST_OK;
                            r.written = 1'b1;
                            r.index = INDEX_W'(i);
                            r.vpage = vpn;
                            r.ppage = ppn;
                        end
                    end
                end
            end
            default:
                r.status = ST_BAD_REQ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want_v, got_v);
        if (got_v !== want_v)
        begin
            $display("%0t ns: %s expected %0h, got %0h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_refills.size() == 0)
            begin
                $display("%0t ns: result transfer with none expected, status %0h",
                         $time, status);
                mismatches++;
            end
            else
            begin
                oldest_refill = pending_refills.pop_front();
                check_field("status", 32'(oldest_refill.status), 32'(status));
                check_field("entry_written", 32'(oldest_refill.written), 32'(entry_written));
                check_field("entry_index", 32'(oldest_refill.index), 32'(entry_index));
                check_field("entry_virt_page", 32'(oldest_refill.vpage), 32'(entry_virt_page));
                check_field("entry_phys_page", 32'(oldest_refill.ppage), 32'(entry_phys_page));
            end
        end
    end

    // Presents one request and returns at the edge where its transfer happens.
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        fault_addr <= addr;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_refills.size() != 0);
    endtask

    task automatic apb_write(input logic [2:0] reg_idx, input logic [CFG_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        seg_regs[reg_idx] = value[PAGE_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_segments(input logic [31:0] cv, cp, cc, dv, dp, dc, sp);
        apb_write(REG_CODE_VIRT, cv);
        apb_write(REG_CODE_PHYS, cp);
        apb_write(REG_CODE_COUNT, cc);
        apb_write(REG_DATA_VIRT, dv);
        apb_write(REG_DATA_PHYS, dp);
        apb_write(REG_DATA_COUNT, dc);
        apb_write(REG_STACK_PHYS, sp);
    endtask

    // Mostly faults aimed inside a segment, with the occasional flush so the TLB
    // both fills up and empties again.
    task automatic run_phase(input int n_items);
        int unsigned       pick;
        int unsigned       base;
        int unsigned       span;
        int                pause_at;
        page_t             vpn;
        logic [REQ_W-1:0]  kind;
        logic [ADDR_W-1:0] addr;
        pause_at = $urandom_range(20, n_items - 20);
        for (int k = 0; k < n_items; k++)
        begin
            if (k == pause_at)
                hold_until_drained();
            pick = $urandom_range(0, 99);
            addr = $urandom;
            kind = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
            if (pick == 0)
                kind = REQ_INVAL;
            else if (pick <= 5)
                kind = REQ_READONLY;
            else if (pick <= 10)
                kind = REQ_W'($urandom_range(4, 7));
            else if (pick > 20)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        base = seg_regs[REG_CODE_VIRT];
                        span = seg_regs[REG_CODE_COUNT];
                    end
                    1:
                    begin
                        base = seg_regs[REG_DATA_VIRT];
                        span = seg_regs[REG_DATA_COUNT];
                    end
                    default:
                    begin
                        base = STACK_BASE;
                        span = STACK_N;
                    end
                endcase
                if (span == 0)
                    vpn = page_t'($urandom);
                else if ($urandom_range(0, 6) == 0)
                    case ($urandom_range(0, 3))
                        0: vpn = page_t'(base - 1);
                        1: vpn = page_t'(base);
                        2: vpn = page_t'(base + span - 1);
                        default: vpn = page_t'(base + span);
                    endcase
                else
                    vpn = page_t'(base + $urandom_range(0, span - 1));
                addr = {vpn, OFFSET_W'($urandom)};
            end
            send_request(kind, addr);
            pending_refills.push_back(predict_refill(kind, addr));
        end
    endtask

    initial
    begin
        refill_t predicted;
        tlb_valid = '0;
        for (int i = 0; i < 7; i++)
            seg_regs[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_N; r++)
        begin
            send_request(fault_rows[r].kind, fault_rows[r].addr);
            predicted = predict_refill(fault_rows[r].kind, fault_rows[r].addr);
            pending_refills.push_back(fault_rows[r].typed ? fault_rows[r].want : predicted);
        end
        hold_until_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                // Everything at its maximum: code is just page 0xFFFFF, data covers the rest.
                0: load_segments(32'hFFFF_FFFF, 32'h000F_FFFF, 32'hFFFF_FFFF,
                                 32'hFFF0_0000, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF);
                1: load_segments(32'h0000_0400, 32'h0001_0000, 32'h0000_0080,
                                 32'h0001_0000, 32'h0002_0000, 32'h0000_0200, 32'h0003_0000);
                2: load_segments(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
                // Code overlaps data and both overlap the stack, with frame wraparound.
                3: load_segments(32'h0007_FFF8, 32'h000F_FFF0, 32'h0000_0010,
                                 32'h0007_FFE0, 32'h0000_0010, 32'h0000_0040, 32'h000F_FFFA);
                default: load_segments($urandom, $urandom,
                                       ($urandom & 32'hFFF0_0000) | $urandom_range(1, 1024),
                                       $urandom, $urandom,
                                       ($urandom & 32'hFFF0_0000) | $urandom_range(0, 4096),
                                       $urandom);
            endcase
            case (phase % 4)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 83;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 83;
                end
                default:
                begin
                    src_idle_pct = 13;
                    sink_stall_pct = 13;
                end
            endcase
            run_phase(PHASE_ITEMS);
            hold_until_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/sttlb_pkg.sv
rtl/sttlb_regs.sv
rtl/sttlb_seg.sv
rtl/segment_translate_tlb_refill_core.sv
verif/tb_top.sv
